### rtl/core/gfm_pkg.sv
// ----------------------------------------------------------------------------
// GF(2^256) multiply/square package
// Shared types, widths and reduction helpers.
// ----------------------------------------------------------------------------
package gfm_pkg;

  localparam int WordW = 64;
  localparam int ElemW = 256;
  localparam int ProdW = 512;
  localparam int DefaultStepBits = 8;

  localparam logic CMD_MUL = 1'b0;
  localparam logic CMD_SQR = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [WordW-1:0] a_w0;
    logic [WordW-1:0] a_w1;
    logic [WordW-1:0] a_w2;
    logic [WordW-1:0] a_w3;
    logic [WordW-1:0] b_w0;
    logic [WordW-1:0] b_w1;
    logic [WordW-1:0] b_w2;
    logic [WordW-1:0] b_w3;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] prod_w3;
    logic [WordW-1:0] prod_w2;
    logic [WordW-1:0] prod_w1;
    logic [WordW-1:0] prod_w0;
  } out_item_t;

  // Folds x^256 terms using x^256 = x^10 + x^5 + x^2 + 1.
  function automatic logic [ElemW-1:0] reduce(input logic [ProdW-1:0] p);
    logic [ElemW+10-1:0] h;
    logic [ElemW+10-1:0] f;
    logic [ElemW-1:0]    g;
    h = {10'd0, p[ProdW-1:ElemW]};
    f = h ^ (h << 10) ^ (h << 5) ^ (h << 2);
    g = {{(ElemW-20){1'b0}}, f[ElemW+10-1:ElemW], 10'd0} ^
        {{(ElemW-15){1'b0}}, f[ElemW+10-1:ElemW], 5'd0} ^
        {{(ElemW-12){1'b0}}, f[ElemW+10-1:ElemW], 2'd0} ^
        {{(ElemW-10){1'b0}}, f[ElemW+10-1:ElemW]};
    return p[ElemW-1:0] ^ f[ElemW-1:0] ^ g;
  endfunction

endpackage

### rtl/core/gfm_if.sv
// ----------------------------------------------------------------------------
// GF(2^256) stream interfaces
// Valid/ready channels for operand items and result items.
// ----------------------------------------------------------------------------
interface gfm_in_if;
  logic valid;
  logic ready;
  gfm_pkg::in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface gfm_out_if;
  logic valid;
  logic ready;
  gfm_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### rtl/core/gfm_cell.sv
// ----------------------------------------------------------------------------
// GF(2^256) multiplier cell
// Consumes StepBits bits of b, accumulates partial products, passes on.
// ----------------------------------------------------------------------------
module gfm_cell #(
  parameter int StepBits = gfm_pkg::DefaultStepBits,
  parameter int Index = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      vin,
  input  logic [gfm_pkg::ElemW-1:0] ain,
  input  logic [gfm_pkg::ElemW-1:0] bin,
  input  logic [gfm_pkg::ProdW-1:0] accin,
  output logic                      vout,
  output logic [gfm_pkg::ElemW-1:0] aout,
  output logic [gfm_pkg::ElemW-1:0] bout,
  output logic [gfm_pkg::ProdW-1:0] accout
);
  logic [gfm_pkg::ProdW-1:0] acc_next;

  always_comb begin
    acc_next = accin;
    for (int k = 0; k < StepBits; k++) begin
      if (bin[Index*StepBits+k]) begin
        acc_next = acc_next ^ ({{gfm_pkg::ElemW{1'b0}}, ain} << (Index*StepBits+k));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vout <= 1'b0;
    end else if (en) begin
      vout <= vin;
    end
    if (en) begin
      aout   <= ain;
      bout   <= bin;
      accout <= acc_next;
    end
  end
endmodule

### rtl/core/gf2_256_multiply_square.sv
// ----------------------------------------------------------------------------
// GF(2^256) multiply and square
// Pipelined carry-less multiply with reduction by x^256+x^10+x^5+x^2+1.
// ----------------------------------------------------------------------------
// Usage: operand items enter on in_ch (cmd, a_w0..a_w3, b_w0..b_w3); each
// gives one result item on out_ch (prod_w0..prod_w3). Command 1 squares a
// and ignores b. A row of 256/StepBits cells each folds StepBits bits of b
// into a running product and hands it on every cycle that the pipe advances;
// a final register reduces the product. One item is accepted per cycle
// while the pipe advances. The whole pipe advances only when the result
// register is free or being read, so a stalled receiver holds every item in
// place and lowers in_ch.ready. Reset empties the pipe.
// ----------------------------------------------------------------------------
module gf2_256_multiply_square #(
  parameter int StepBits = gfm_pkg::DefaultStepBits
) (
  input logic    clk,
  input logic    rst,
  gfm_in_if.sink in_ch,
  gfm_out_if.source out_ch
);
  localparam int NCells = gfm_pkg::ElemW / StepBits;

  logic                      en;
  logic [NCells:0]           v;
  logic [gfm_pkg::ElemW-1:0] a [NCells+1];
  logic [gfm_pkg::ElemW-1:0] b [NCells+1];
  logic [gfm_pkg::ProdW-1:0] acc [NCells+1];
  logic                      ovalid;
  gfm_pkg::out_item_t        odata;

  assign en = !ovalid || out_ch.ready;
  assign in_ch.ready = en;
  assign v[0] = in_ch.valid;
  assign a[0] = {in_ch.data.a_w3, in_ch.data.a_w2, in_ch.data.a_w1, in_ch.data.a_w0};
  assign b[0] = (in_ch.data.cmd == gfm_pkg::CMD_SQR) ? a[0] :
                {in_ch.data.b_w3, in_ch.data.b_w2, in_ch.data.b_w1, in_ch.data.b_w0};
  assign acc[0] = '0;

  for (genvar i = 0; i < NCells; i++) begin : g_cell
    gfm_cell #(.StepBits(StepBits), .Index(i)) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .vin(v[i]), .ain(a[i]), .bin(b[i]), .accin(acc[i]),
      .vout(v[i+1]), .aout(a[i+1]), .bout(b[i+1]), .accout(acc[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (en) begin
      ovalid <= v[NCells];
    end
    if (en) begin
      odata <= gfm_pkg::out_item_t'(gfm_pkg::reduce(acc[NCells]));
    end
  end

  assign out_ch.valid = ovalid;
  assign out_ch.data  = odata;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    ovalid && !out_ch.ready |=> ovalid && $stable(odata))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !ovalid |-> in_ch.ready)
    else $error("input blocked with empty output");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    en && v[NCells] |=> ovalid)
    else $error("result lost at pipe end");
endmodule
